[rtl/gdfo_pkg.sv]
// ----------------------------------------------------------------------------
// gdfo_pkg
// Shared types and constants for the depth-first order walker.
// ----------------------------------------------------------------------------
package gdfo_pkg;

  localparam int VERTEX_W  = 3;
  localparam int RANK_W    = 4;
  localparam int COUNT_W   = 4;
  localparam int ADJ_W     = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = ADJ_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ADJACENCY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd1;

  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAD,
    ST_POP,
    ST_WAIT,
    ST_SCAN,
    ST_FINISH
  } walk_state_t;

endpackage

[rtl/gdfo_if.sv]
// ----------------------------------------------------------------------------
// gdfo_if
// Valid/ready channels for start requests and visit results.
// ----------------------------------------------------------------------------
interface gdfo_start_if
  import gdfo_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] start_vertex;

  modport source (output valid, output start_vertex, input ready);
  modport sink   (input valid, input start_vertex, output ready);
endinterface

interface gdfo_visit_if
  import gdfo_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] visited_vertex;
  logic [RANK_W-1:0]   visit_rank;
  logic                last_of_walk;
  logic                bad_start;

  modport source (output valid, output visited_vertex, output visit_rank,
                  output last_of_walk, output bad_start, input ready);
  modport sink   (input valid, input visited_vertex, input visit_rank,
                  input last_of_walk, input bad_start, output ready);
endinterface

[rtl/gdfo_stack.sv]
// ----------------------------------------------------------------------------
// gdfo_stack
// Pending-vertex stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gdfo_stack
  import gdfo_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [VERTEX_W-1:0] wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic [VERTEX_W-1:0] rd_data
);

  logic [VERTEX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/gdfo_ctrl.sv]
// ----------------------------------------------------------------------------
// gdfo_ctrl
// Walk sequencer: pops, marks visited, scans neighbors, emits results.
// ----------------------------------------------------------------------------
module gdfo_ctrl
  import gdfo_pkg::*;
#(
  parameter int MAX_VERTICES = 8,
  parameter int STACK_DEPTH  = 32,
  parameter int AW           = $clog2(STACK_DEPTH),
  parameter int SP_W         = $clog2(STACK_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ADJ_W-1:0]    adjacency_bits,
  input  logic [COUNT_W-1:0]  vertex_count,
  gdfo_start_if.sink          walk_in,
  gdfo_visit_if.source        visit_out,
  output logic                mem_wr_en,
  output logic [AW-1:0]       mem_wr_addr,
  output logic [VERTEX_W-1:0] mem_wr_data,
  output logic                mem_rd_en,
  output logic [AW-1:0]       mem_rd_addr,
  input  logic [VERTEX_W-1:0] mem_rd_data
);

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);
  localparam logic [SP_W-1:0]    SP_FULL   = SP_W'(STACK_DEPTH);

  walk_state_t state, state_next;

  logic [SP_W-1:0]       sp;
  logic [7:0]            visited;
  logic [RANK_W-1:0]     visit_counter;
  logic [VERTEX_W-1:0]   cur_u;
  logic [VERTEX_W-1:0]   v_idx;
  logic [COUNT_W-1:0]    count_reg;
  logic [VERTEX_W-1:0]   pend_vertex;
  logic [RANK_W-1:0]     pend_rank;
  logic                  have_pend;

  logic                  out_valid;
  logic [VERTEX_W-1:0]   out_vertex;
  logic [RANK_W-1:0]     out_rank;
  logic                  out_last;
  logic                  out_bad;

  logic [COUNT_W-1:0]    count_eff;
  logic                  start_bad;
  logic                  accept;
  logic                  out_free;
  logic                  u_seen;
  logic                  push_ok;

  logic                  load;
  logic [VERTEX_W-1:0]   ld_vertex;
  logic [RANK_W-1:0]     ld_rank;
  logic                  ld_last;
  logic                  ld_bad;

  assign count_eff = (vertex_count > MAX_COUNT) ? MAX_COUNT : vertex_count;
  assign start_bad = {1'b0, walk_in.start_vertex} >= count_eff;
  assign accept    = walk_in.valid && walk_in.ready;
  assign out_free  = !out_valid || visit_out.ready;
  assign u_seen    = visited[mem_rd_data];
  assign push_ok   = adjacency_bits[{cur_u, v_idx}] && !visited[v_idx] && (sp < SP_FULL);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (walk_in.valid) state_next = start_bad ? ST_BAD : ST_POP;
      ST_BAD:    if (out_free) state_next = ST_IDLE;
      ST_POP:    state_next = (sp == '0) ? ST_FINISH : ST_WAIT;
      ST_WAIT: begin
        if (u_seen) begin
          state_next = ST_POP;
        end else if (!have_pend || out_free) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN:   if (v_idx == '0) state_next = ST_POP;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs and strobes
  always_comb begin
    walk_in.ready = 1'b0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = sp[AW-1:0];
    mem_wr_data   = v_idx;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = AW'(sp - SP_W'(1));
    load          = 1'b0;
    ld_vertex     = pend_vertex;
    ld_rank       = pend_rank;
    ld_last       = 1'b0;
    ld_bad        = 1'b0;
    case (state)
      ST_IDLE: begin
        walk_in.ready = 1'b1;
        mem_wr_en     = walk_in.valid && !start_bad;
        mem_wr_addr   = '0;
        mem_wr_data   = walk_in.start_vertex;
      end
      ST_BAD: begin
        load      = out_free;
        ld_vertex = '0;
        ld_rank   = '0;
        ld_last   = 1'b1;
        ld_bad    = 1'b1;
      end
      ST_POP:    mem_rd_en = (sp != '0);
      ST_WAIT:   load = !u_seen && have_pend && out_free;
      ST_SCAN:   mem_wr_en = push_ok;
      ST_FINISH: begin
        load    = out_free;
        ld_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sp            <= '0;
      visited       <= '0;
      visit_counter <= '0;
      have_pend     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (visit_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && !start_bad) begin
            sp            <= SP_W'(1);
            visited       <= '0;
            visit_counter <= '0;
            have_pend     <= 1'b0;
            count_reg     <= count_eff;
          end
        end
        ST_POP: begin
          if (sp != '0) sp <= sp - SP_W'(1);
        end
        ST_WAIT: begin
          if (!u_seen && (!have_pend || out_free)) begin
            visited[mem_rd_data] <= 1'b1;
            visit_counter        <= visit_counter + RANK_W'(1);
            pend_vertex          <= mem_rd_data;
            pend_rank            <= visit_counter + RANK_W'(1);
            have_pend            <= 1'b1;
            cur_u                <= mem_rd_data;
            v_idx                <= VERTEX_W'(count_reg - COUNT_W'(1));
          end
        end
        ST_SCAN: begin
          if (push_ok) sp <= sp + SP_W'(1);
          v_idx <= v_idx - VERTEX_W'(1);
        end
        ST_FINISH: begin
          if (out_free) have_pend <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      out_vertex <= ld_vertex;
      out_rank   <= ld_rank;
      out_last   <= ld_last;
      out_bad    <= ld_bad;
    end
  end

  assign visit_out.valid          = out_valid;
  assign visit_out.visited_vertex = out_vertex;
  assign visit_out.visit_rank     = out_rank;
  assign visit_out.last_of_walk   = out_last;
  assign visit_out.bad_start      = out_bad;

endmodule

[rtl/graph_depth_first_order.sv]
// ----------------------------------------------------------------------------
// graph_depth_first_order
// Depth-first visit order of a graph of up to eight vertices.
// ----------------------------------------------------------------------------
// Usage:
//   walk_in carries one start vertex per transaction. visit_out returns one
//   transaction per newly visited vertex, in depth-first order (lowest
//   neighbor first), with its one-based rank; the final one of a walk has
//   last_of_walk set. A start at or above vertex_count gives one transaction
//   with bad_start and last_of_walk set.
//   Configuration (adjacency matrix, vertex count) is written through the
//   cfg_* port while no walk is in progress.
// Operation:
//   Pending vertices live in a stack RAM with one write port and one
//   registered read port. Each pop sends the address in the pop state and
//   takes the data in the wait state; each visited vertex is followed by a
//   scan of all vertex_count candidate neighbors, one push at most per cycle.
//   A walk ends with a final empty pop and the finish state; a bad start
//   goes through the bad state only.
//   A result is held back until the next visit (or the empty stack) shows
//   whether it is the last, so the first result appears no earlier than the
//   end of the scan of the start vertex's neighbors. A new start is taken
//   once the previous walk is finished.
// Reset and stall:
//   rst (synchronous) returns to idle, empties the stack and restores the
//   register defaults. A stalled receiver holds the output register and the
//   walk pauses until it drains; no result is lost.
// ----------------------------------------------------------------------------
module graph_depth_first_order
  import gdfo_pkg::*;
#(
  parameter int MAX_VERTICES = 8,
  parameter int STACK_DEPTH  = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  gdfo_start_if.sink            walk_in,
  gdfo_visit_if.source          visit_out
);

  localparam int AW = $clog2(STACK_DEPTH);

  // configuration registers
  logic [ADJ_W-1:0]   adjacency_bits;
  logic [COUNT_W-1:0] vertex_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      adjacency_bits <= '0;
      vertex_count   <= VERTEX_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ADJACENCY:    adjacency_bits <= cfg_data;
        REG_VERTEX_COUNT: vertex_count   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // stack RAM port
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [VERTEX_W-1:0] mem_wr_data;
  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic [VERTEX_W-1:0] mem_rd_data;

  gdfo_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .STACK_DEPTH  (STACK_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .adjacency_bits (adjacency_bits),
    .vertex_count   (vertex_count),
    .walk_in        (walk_in),
    .visit_out      (visit_out),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  gdfo_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
